// ----- src/enms_pkg.sv -----
// ----------------------------------------------------------------------------
// enms_pkg
// shared types, constants and the angle-to-sector function for the edge
// non-maximum suppression block
// ----------------------------------------------------------------------------
`default_nettype none

package enms_pkg;

    // frame geometry
    localparam int MAX_WIDTH = 1024;
    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int ROW_BITS  = 12;
    localparam int WID_BITS  = 11;
    localparam int CFG_BITS  = 12;
    localparam int MAG_BITS  = 16;
    localparam int DIR_BITS  = 15;

    // configuration register indexes
    localparam int            CFG_IDX_BITS     = 1;
    localparam logic [0:0]    REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [0:0]    REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WID_BITS-1:0] WIDTH_RESET  = WID_BITS'(640);
    localparam logic [ROW_BITS-1:0] HEIGHT_RESET = ROW_BITS'(480);
    localparam logic [WID_BITS-1:0] WIDTH_MIN    = WID_BITS'(3);
    localparam logic [WID_BITS-1:0] WIDTH_MAX    = WID_BITS'(MAX_WIDTH);
    localparam logic [ROW_BITS-1:0] HEIGHT_MIN   = ROW_BITS'(3);

    // angle thresholds in q3.12 radians
    localparam logic signed [DIR_BITS:0] ANGLE_FOLD = 16'sd12868;
    localparam logic signed [DIR_BITS:0] EDGE_A     = 16'sd1608;
    localparam logic signed [DIR_BITS:0] EDGE_B     = 16'sd4825;
    localparam logic signed [DIR_BITS:0] EDGE_C     = 16'sd8042;
    localparam logic signed [DIR_BITS:0] EDGE_D     = 16'sd11259;

    typedef enum logic [1:0] {
        SECTOR_0   = 2'd0,
        SECTOR_45  = 2'd1,
        SECTOR_90  = 2'd2,
        SECTOR_135 = 2'd3
    } sector_t;

    // one column of the 3x3 window, sector belongs to the middle row
    typedef struct packed {
        logic [MAG_BITS-1:0] top;
        logic [MAG_BITS-1:0] mid;
        logic [MAG_BITS-1:0] bot;
        sector_t             sec;
    } window_col_t;

    // one line store entry: rows r-2 and r-1 plus the sector of row r-1
    typedef struct packed {
        logic [MAG_BITS-1:0] older;
        logic [MAG_BITS-1:0] recent;
        sector_t             sec;
    } line_word_t;

    localparam int LINE_WORD_BITS = $bits(line_word_t);

    // shift control into the window cells
    typedef struct packed {
        logic shift;
    } cell_ctrl_t;

    function automatic sector_t sector_of(input logic signed [DIR_BITS-1:0] dir);
        logic signed [DIR_BITS:0] a;
        sector_t                  s;
        a = {dir[DIR_BITS-1], dir};
        if (a < 0)
        begin
            a = a + ANGLE_FOLD;
        end
        if (a >= EDGE_A && a < EDGE_B)
        begin
            s = SECTOR_45;
        end
        else if (a >= EDGE_B && a < EDGE_C)
        begin
            s = SECTOR_90;
        end
        else if (a >= EDGE_C && a < EDGE_D)
        begin
            s = SECTOR_135;
        end
        else
        begin
            s = SECTOR_0;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- src/edge_non_maximum_suppression.sv -----
// ----------------------------------------------------------------------------
// edge_non_maximum_suppression
// canny thinning step over a raster-order stream of gradient pixels
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled, with no gaps
// needed between frames. Each pixel passes one register stage, stage a
// (counters step, line store read issued, sector classified), where its line
// store data and the window cells meet it; when stage a moves on, the result
// of the 3x3 window with it at the lower right is loaded into the output
// register. A result held in the output register blocks input only once stage
// a holds another interior pixel. The rate is set by the single line store
// ram (one read and one write port, 1024 x 34 bits, rows r-2 and r-1 plus
// sectors), which sees at most one read and one write each cycle. Border
// pixels give no result. The line store is not cleared after reset; the first
// two rows of a frame fill it before any result reads it. The user must write
// image_width and image_height through the cfg port only while the block is
// idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_non_maximum_suppression (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // configuration
    input  wire logic                                   cfg_we,
    input  wire logic [enms_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [enms_pkg::CFG_BITS-1:0]          cfg_data,
    // pixel input
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [enms_pkg::MAG_BITS-1:0]          magnitude,
    input  wire logic signed [enms_pkg::DIR_BITS-1:0]   direction,
    // result output
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [enms_pkg::MAG_BITS-1:0]               kept_magnitude,
    output logic [enms_pkg::COL_BITS-1:0]               column,
    output logic [enms_pkg::ROW_BITS-1:0]               row
);

    // configuration registers
    logic [enms_pkg::WID_BITS-1:0] width_reg;
    logic [enms_pkg::ROW_BITS-1:0] height_reg;
    logic [enms_pkg::WID_BITS-1:0] width_eff;
    logic [enms_pkg::ROW_BITS-1:0] height_eff;

    // raster position of the next pixel
    logic [enms_pkg::COL_BITS-1:0] column_count_reg;
    logic [enms_pkg::COL_BITS-1:0] column_count_next;
    logic [enms_pkg::ROW_BITS-1:0] row_count_reg;
    logic [enms_pkg::ROW_BITS-1:0] row_count_next;
    logic                          col_wrap;

    // stage a: pixel waiting for its line store data
    logic                          a_valid_reg;
    logic [enms_pkg::MAG_BITS-1:0] a_mag_reg;
    enms_pkg::sector_t             a_sec_reg;
    logic [enms_pkg::COL_BITS-1:0] a_col_reg;
    logic [enms_pkg::ROW_BITS-1:0] a_row_reg;
    logic                          a_emit;
    logic                          advance_a;
    logic                          in_xfer;

    // output register
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [enms_pkg::MAG_BITS-1:0] kept_reg;
    logic [enms_pkg::COL_BITS-1:0] out_col_reg;
    logic [enms_pkg::ROW_BITS-1:0] out_row_reg;
    logic                          out_free;

    // line store and window
    enms_pkg::line_word_t          rd_word;
    enms_pkg::line_word_t          wr_word;
    logic [enms_pkg::LINE_WORD_BITS-1:0] rd_bits;
    enms_pkg::window_col_t         new_col;
    enms_pkg::window_col_t         left_col;
    enms_pkg::window_col_t         centre_col;
    enms_pkg::cell_ctrl_t          cell_ctrl;
    logic [enms_pkg::MAG_BITS-1:0] kept_value;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= enms_pkg::WIDTH_RESET;
            height_reg <= enms_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                enms_pkg::REG_IMAGE_WIDTH:
                begin
                    width_reg <= cfg_data[enms_pkg::WID_BITS-1:0];
                end
                enms_pkg::REG_IMAGE_HEIGHT:
                begin
                    height_reg <= cfg_data;
                end
                default:
                begin
                    width_reg <= width_reg;
                end
            endcase
        end
    end

    // clamp the width to what the line store can hold, and both sizes to their minimum
    always_comb
    begin
        width_eff = width_reg;
        if (width_reg < enms_pkg::WIDTH_MIN)
        begin
            width_eff = enms_pkg::WIDTH_MIN;
        end
        else if (width_reg > enms_pkg::WIDTH_MAX)
        begin
            width_eff = enms_pkg::WIDTH_MAX;
        end
        height_eff = height_reg;
        if (height_reg < enms_pkg::HEIGHT_MIN)
        begin
            height_eff = enms_pkg::HEIGHT_MIN;
        end
    end

    // ------------------------------------------------------------------
    // handshake: stage a moves on when its result has room, or it has none
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || out_ready;
    assign a_emit    = (a_col_reg >= enms_pkg::COL_BITS'(2))
                    && (a_row_reg >= enms_pkg::ROW_BITS'(2));
    assign advance_a = a_valid_reg && (out_free || !a_emit);
    assign in_ready  = !a_valid_reg || advance_a;
    assign in_xfer   = in_valid && in_ready;

    // ------------------------------------------------------------------
    // raster counters, step on every input transfer
    // ------------------------------------------------------------------
    always_comb
    begin
        col_wrap = ({1'b0, column_count_reg} + (enms_pkg::COL_BITS + 1)'(1))
                >= (enms_pkg::COL_BITS + 1)'(width_eff);
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (in_xfer)
        begin
            if (col_wrap)
            begin
                column_count_next = '0;
                if (({1'b0, row_count_reg} + (enms_pkg::ROW_BITS + 1)'(1))
                    >= {1'b0, height_eff})
                begin
                    row_count_next = '0;
                end
                else
                begin
                    row_count_next = row_count_reg + enms_pkg::ROW_BITS'(1);
                end
            end
            else
            begin
                column_count_next = column_count_reg + enms_pkg::COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // ------------------------------------------------------------------
    // stage a
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            a_mag_reg <= magnitude;
            a_sec_reg <= enms_pkg::sector_of(direction);
            a_col_reg <= column_count_reg;
            a_row_reg <= row_count_reg;
        end
    end

    // ------------------------------------------------------------------
    // line store: read at transfer, written back when stage a moves on;
    // the same column is never touched by two pixels closer than three apart
    // ------------------------------------------------------------------
    assign wr_word.older  = rd_word.recent;
    assign wr_word.recent = a_mag_reg;
    assign wr_word.sec    = a_sec_reg;

    enms_ram #(
        .WIDTH (enms_pkg::LINE_WORD_BITS),
        .DEPTH (enms_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (advance_a),
        .waddr (a_col_reg),
        .wdata (wr_word),
        .re    (in_xfer),
        .raddr (column_count_reg),
        .rdata (rd_bits)
    );

    assign rd_word = enms_pkg::line_word_t'(rd_bits);

    // ------------------------------------------------------------------
    // window: two cells hold the left and centre columns, the right column
    // is the incoming one
    // ------------------------------------------------------------------
    assign new_col.top    = rd_word.older;
    assign new_col.mid    = rd_word.recent;
    assign new_col.bot    = a_mag_reg;
    assign new_col.sec    = rd_word.sec;
    assign cell_ctrl.shift = advance_a;

    // the window after this pixel's shift is {old centre, old right, new}
    enms_pkg::window_col_t right_col;

    enms_window_cell u_cell_left (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cell_ctrl),
        .col_in  (right_col),
        .col_out (left_col)
    );

    enms_window_cell u_cell_right (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (cell_ctrl),
        .col_in  (new_col),
        .col_out (right_col)
    );

    // after the shift: left <- u_cell_left's input side, centre <- right cell
    assign centre_col = right_col;

    enms_keep_test u_keep (
        .left   (left_col),
        .centre (centre_col),
        .right  (new_col),
        .kept   (kept_value)
    );

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (advance_a && a_emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance_a && a_emit)
        begin
            kept_reg    <= kept_value;
            out_col_reg <= a_col_reg - enms_pkg::COL_BITS'(1);
            out_row_reg <= a_row_reg - enms_pkg::ROW_BITS'(1);
        end
    end

    assign out_valid      = out_valid_reg;
    assign kept_magnitude = kept_reg;
    assign column         = out_col_reg;
    assign row            = out_row_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // a result never belongs to the top row or left column
    a_no_border: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (column != '0) && (row != '0))
        else $error("result emitted for a border pixel");

    // a full stage a that cannot move must block new transfers
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !advance_a) |-> !in_ready)
        else $error("input taken while stage a is stalled");

    // an interior pixel leaving stage a always lands in the output register
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (advance_a && a_emit) |=> out_valid_reg)
        else $error("interior result lost");

    // the row counter only moves at the end of a line
    a_row_steps: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_xfer && col_wrap) |=> $stable(row_count_reg))
        else $error("row counter moved mid-line");

endmodule

`default_nettype wire

// ----- src/enms_ram.sv -----
// ----------------------------------------------------------------------------
// enms_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module enms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/enms_window_cell.sv -----
// ----------------------------------------------------------------------------
// enms_window_cell
// one column of the 3x3 window, hands its column to the left neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module enms_window_cell (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire enms_pkg::cell_ctrl_t ctrl,
    input  wire enms_pkg::window_col_t col_in,
    output enms_pkg::window_col_t     col_out
);

    enms_pkg::window_col_t col_reg;
    enms_pkg::window_col_t col_next;

    always_comb
    begin
        col_next = col_reg;
        if (ctrl.shift)
        begin
            col_next = col_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
        end
    end

    assign col_out = col_reg;

endmodule

`default_nettype wire

// ----- src/enms_keep_test.sv -----
// ----------------------------------------------------------------------------
// enms_keep_test
// picks the two neighbors along the centre sector and keeps the centre
// magnitude only if it is at least both
// ----------------------------------------------------------------------------
`default_nettype none

module enms_keep_test (
    input  wire enms_pkg::window_col_t         left,
    input  wire enms_pkg::window_col_t         centre,
    input  wire enms_pkg::window_col_t         right,
    output logic [enms_pkg::MAG_BITS-1:0]      kept
);

    logic [enms_pkg::MAG_BITS-1:0] n1;
    logic [enms_pkg::MAG_BITS-1:0] n2;

    always_comb
    begin
        case (centre.sec)
            enms_pkg::SECTOR_45:
            begin
                n1 = right.top;
                n2 = left.bot;
            end
            enms_pkg::SECTOR_90:
            begin
                n1 = left.mid;
                n2 = right.mid;
            end
            enms_pkg::SECTOR_135:
            begin
                n1 = left.top;
                n2 = right.bot;
            end
            default:
            begin
                n1 = centre.top;
                n2 = centre.bot;
            end
        endcase
    end

    assign kept = (centre.mid >= n1 && centre.mid >= n2) ? centre.mid : '0;

endmodule

`default_nettype wire
